[rtl/multichannel_fir_lowpass_top_defines.svh]
// Assertion macros used by the checker file of the multichannel FIR block.
`ifndef MULTICHANNEL_FIR_LOWPASS_TOP_DEFINES_SVH
`define MULTICHANNEL_FIR_LOWPASS_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFIRLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfirlp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MFIRLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfirlp assertion failed");

`endif

[rtl/mfirlp_pkg.sv]
// Package with constants, coefficient table and shared types of the multichannel FIR.
package mfirlp_pkg;

  localparam int DEF_TAPS        = 81;
  localparam int DEF_CHANNELS    = 64;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int CHANNEL_BITS = 6;
  localparam int CIU_BITS     = 7;
  localparam logic [CIU_BITS-1:0] CIU_RESET = 7'd64;

  localparam int COEF_BITS = 18;
  localparam int FRAC_BITS = COEF_BITS - 1;
  localparam int TABLE_LEN = 81;
  localparam int TIDX_W    = 7;
  localparam int KIDX_W    = 8;

  // Low-pass coefficients in Q1.17, newest sample against entry 0.
  localparam logic signed [COEF_BITS-1:0] COEF_TABLE [TABLE_LEN] = '{
    18'sd58,    18'sd88,    18'sd120,   18'sd151,   18'sd179,
    18'sd200,   18'sd209,   18'sd203,   18'sd178,   18'sd131,
    18'sd60,    -18'sd36,   -18'sd155,  -18'sd295,  -18'sd449,
    -18'sd611,  -18'sd772,  -18'sd919,  -18'sd1040, -18'sd1122,
    -18'sd1152, -18'sd1116, -18'sd1002, -18'sd802,  -18'sd507,
    -18'sd115,  18'sd375,   18'sd956,   18'sd1622,  18'sd2357,
    18'sd3145,  18'sd3966,  18'sd4796,  18'sd5609,  18'sd6381,
    18'sd7086,  18'sd7699,  18'sd8201,  18'sd8572,  18'sd8800,
    18'sd8877,
    18'sd8800,  18'sd8572,  18'sd8201,  18'sd7699,  18'sd7086,
    18'sd6381,  18'sd5609,  18'sd4796,  18'sd3966,  18'sd3145,
    18'sd2357,  18'sd1622,  18'sd956,   18'sd375,   -18'sd115,
    -18'sd507,  -18'sd802,  -18'sd1002, -18'sd1116, -18'sd1152,
    -18'sd1122, -18'sd1040, -18'sd919,  -18'sd772,  -18'sd611,
    -18'sd449,  -18'sd295,  -18'sd155,  -18'sd36,   18'sd60,
    18'sd131,   18'sd178,   18'sd203,   18'sd209,   18'sd200,
    18'sd179,   18'sd151,   18'sd120,   18'sd88,    18'sd58
  };

  // Taps past the end of the table weigh zero.
  function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [KIDX_W-1:0] k);
    logic signed [COEF_BITS-1:0] c;
    c = '0;
    if (k < KIDX_W'(TABLE_LEN)) begin
      c = COEF_TABLE[k[TIDX_W-1:0]];
    end
    return c;
  endfunction

  typedef struct packed {
    logic              clr;
    logic              en;
    logic [KIDX_W-1:0] k;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FINISH
  } seq_state_e;

endpackage

[rtl/mfirlp_mac.sv]
// Shared multiply-accumulate unit with rounding and saturation of the filter sum.
module mfirlp_mac
  import mfirlp_pkg::*;
#(
  parameter int TAPS        = DEF_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mac_ctl_t                      ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] data_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_o
);

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam int RW     = ACC_W + 1;

  localparam logic signed [RW-1:0] RND  = RW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [RW-1:0] MAXV =
    {{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] MINV =
    {{(RW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_q;
  logic                     pvld_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [RW-1:0]     rnd, shifted, sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= ctl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= data_i * coef_at(ctl_i.k);
    acc_q  <= acc_d;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (pvld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  // Round half up, drop the fraction bits, then saturate to the sample range.
  always_comb begin
    rnd     = RW'(acc_q) + RND;
    shifted = rnd >>> FRAC_BITS;
    sat     = shifted;
    if (shifted > MAXV) begin
      sat = MAXV;
    end else if (shifted < MINV) begin
      sat = MINV;
    end
  end

  assign filtered_o = sat[SAMPLE_BITS-1:0];

endmodule

[rtl/multichannel_fir_lowpass_top.sv]
// Multichannel FIR low-pass filter: each accepted sample for a valid channel enters its
// channel's ring buffer, and one output value comes back for every accepted sample. After
// reset the block first zeroes the delay memory, one entry per cycle, and the ring
// positions, and stalls input meanwhile; configuration writes are taken at any time.
// An accepted sample for a valid channel runs through ST_WRITE, then ST_MAC with one
// multiply-accumulate per tap through the single multiplier and the one read port of the
// delay memory, the pipeline drain states ST_DRAIN1 and ST_DRAIN2, ST_FINISH to load the
// output register and ST_IDLE, in which the next sample is accepted. A rejected channel
// goes from ST_IDLE straight to ST_FINISH and leaves all filter state untouched. While a
// finished result waits on a stalled output register, the sequencer holds in ST_FINISH.
module multichannel_fir_lowpass_top
  import mfirlp_pkg::*;
#(
  parameter int TAPS        = DEF_TAPS,
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CIU_BITS-1:0]           cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [CHANNEL_BITS-1:0]       channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CHANNEL_BITS-1:0]       out_channel_o,
  output logic signed [SAMPLE_BITS-1:0] filtered_o,
  output logic                          channel_error_o
);

  localparam int DEPTH    = CHANNELS * TAPS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W    = $clog2(TAPS);

  seq_state_e state_q, state_d;

  logic [CIU_BITS-1:0]           ciu_q;
  logic [ADDR_W-1:0]             clr_cnt_q, clr_cnt_d;
  logic [CHANNEL_BITS-1:0]       ch_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          err_q;
  logic [ADDR_W-1:0]             base_q;
  logic [POS_W-1:0]              pos_rd_q, pos_cur, pos_next;
  logic [POS_W-1:0]              idx_q, idx_d;
  logic [KIDX_W-1:0]             k_q, k_d, k1_q;
  logic                          rvld_q;

  logic                          in_accept, ch_err, clr_done, out_free, out_load;
  logic                          dm_we, dm_re, pm_we;
  logic [ADDR_W-1:0]             dm_waddr, dm_raddr;
  logic signed [SAMPLE_BITS-1:0] dm_wdata, dm_rdata_q;
  logic [CH_IDX_W-1:0]           pm_waddr;
  logic [POS_W-1:0]              pm_wdata;

  logic signed [SAMPLE_BITS-1:0] dmem [DEPTH];
  logic [POS_W-1:0]              pos_mem [CHANNELS];

  mac_ctl_t                      mac_ctl;
  logic signed [SAMPLE_BITS-1:0] mac_filtered;

  logic                          out_valid_q;
  logic [CHANNEL_BITS-1:0]       out_channel_q;
  logic signed [SAMPLE_BITS-1:0] filtered_q;
  logic                          out_err_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign ch_err    = (CIU_BITS'(channel_i) >= ciu_q) || (9'(channel_i) >= 9'(CHANNELS));
  assign clr_done  = (clr_cnt_q == ADDR_W'(DEPTH - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  // A ring position outside the buffer is treated as position zero.
  assign pos_cur  = (pos_rd_q > POS_W'(TAPS - 1)) ? '0 : pos_rd_q;
  assign pos_next = (pos_cur == POS_W'(TAPS - 1)) ? '0 : pos_cur + 1'b1;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ch_err ? ST_FINISH : ST_WRITE;
        end
      end
      ST_WRITE:  state_d = ST_MAC;
      ST_MAC: begin
        if (k_q == KIDX_W'(TAPS - 1)) begin
          state_d = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input stall, memory ports, counters, MAC control and output load.
  always_comb begin
    in_stall_o  = 1'b1;
    clr_cnt_d   = clr_cnt_q;
    idx_d       = idx_q;
    k_d         = k_q;
    dm_we       = 1'b0;
    dm_re       = 1'b0;
    dm_waddr    = base_q + ADDR_W'(pos_cur);
    dm_wdata    = sample_q;
    dm_raddr    = base_q + ADDR_W'(idx_q);
    pm_we       = 1'b0;
    pm_waddr    = CH_IDX_W'(ch_q);
    pm_wdata    = pos_next;
    out_load    = 1'b0;
    mac_ctl.clr = 1'b0;
    mac_ctl.en  = rvld_q;
    mac_ctl.k   = k1_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        dm_we     = 1'b1;
        dm_waddr  = clr_cnt_q;
        dm_wdata  = '0;
        pm_we     = (clr_cnt_q < ADDR_W'(CHANNELS));
        pm_waddr  = CH_IDX_W'(clr_cnt_q);
        pm_wdata  = '0;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_WRITE: begin
        dm_we       = 1'b1;
        pm_we       = 1'b1;
        idx_d       = pos_cur;
        k_d         = '0;
        mac_ctl.clr = 1'b1;
      end
      ST_MAC: begin
        dm_re = 1'b1;
        k_d   = k_q + 1'b1;
        idx_d = (idx_q == '0) ? POS_W'(TAPS - 1) : idx_q - 1'b1;
      end
      ST_DRAIN1, ST_DRAIN2: begin
      end
      ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      ciu_q       <= CIU_RESET;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      rvld_q    <= dm_re;
      if (cfg_we_i) begin
        ciu_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    k_q   <= k_d;
    k1_q  <= k_q;
    if (in_accept) begin
      ch_q     <= channel_i;
      sample_q <= sample_i;
      err_q    <= ch_err;
      base_q   <= ADDR_W'(CH_IDX_W'(channel_i) * TAPS);
      if (!ch_err) begin
        pos_rd_q <= pos_mem[CH_IDX_W'(channel_i)];
      end
    end
    if (out_load) begin
      out_channel_q <= ch_q;
      out_err_q     <= err_q;
      filtered_q    <= err_q ? '0 : mac_filtered;
    end
  end

  // Delay memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_rdata_q <= dmem[dm_raddr];
    end
  end

  // Ring write positions, one per channel.
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pos_mem[pm_waddr] <= pm_wdata;
    end
  end

  mfirlp_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mac_ctl),
    .data_i     (dm_rdata_q),
    .filtered_o (mac_filtered)
  );

  assign out_valid_o     = out_valid_q;
  assign out_channel_o   = out_channel_q;
  assign filtered_o      = filtered_q;
  assign channel_error_o = out_err_q;

endmodule

[rtl/mfirlp_chk.sv]
// Port-level checker for the multichannel FIR, bound to the top level.
`include "multichannel_fir_lowpass_top_defines.svh"

module mfirlp_chk
  import mfirlp_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [CHANNEL_BITS-1:0]       out_channel_o,
  input logic signed [SAMPLE_BITS-1:0] filtered_o,
  input logic                          channel_error_o
);

  // A stalled result holds until it is transferred.
  `MFIRLP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(filtered_o) && $stable(out_channel_o) && $stable(channel_error_o))

  // A rejected channel always reports a zero value.
  `MFIRLP_ASSERT_NOW(a_err_zero, out_valid_o && channel_error_o, filtered_o == '0)

  // The block works on one sample at a time.
  `MFIRLP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // When out_valid_o rises, the sequencer is back in idle and input is not stalled.
  `MFIRLP_ASSERT_NOW(a_result_frees_input, $rose(out_valid_o), !in_stall_o)

endmodule

bind multichannel_fir_lowpass_top mfirlp_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mfirlp_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_channel_o   (out_channel_o),
  .filtered_o      (filtered_o),
  .channel_error_o (channel_error_o)
);
